// ===== hw/rtl/controller_memory_map_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Controller memory map assertion macros
// Shared concurrent assertion forms for the memory map checker.
// ----------------------------------------------------------------------------
`ifndef CONTROLLER_MEMORY_MAP_UNIT_MACROS_SVH
`define CONTROLLER_MEMORY_MAP_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CMM_ASSERT_SAME(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("Same-cycle check failed.");

// Next-cycle implication, disabled while reset is asserted.
`define CMM_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("Next-cycle check failed.");

`endif

// ===== hw/rtl/cmm_pkg.sv =====
// ----------------------------------------------------------------------------
// Controller memory map package
// Status codes, block bases and the reset image of the EEPROM.
// ----------------------------------------------------------------------------
package cmm_pkg;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_ADDR = 2'd1,
        ST_NACK     = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    localparam logic [7:0] BASE_SPEAKER   = 8'hA2;
    localparam logic [7:0] BASE_EXTENSION = 8'hA4;
    localparam logic [7:0] BASE_MOTION    = 8'hA6;
    localparam logic [7:0] BASE_IR        = 8'hB0;

    localparam logic [15:0] TAIL_BASE = 16'h16D0;
    localparam logic [15:0] TAIL_END  = 16'h1700;
    localparam logic [15:0] CAL_END   = 16'h0040;

    localparam logic [7:0] CAL_IMAGE [64] = '{
        8'hA1, 8'hAA, 8'h8B, 8'h99, 8'hAE, 8'h9E, 8'h78, 8'h30,
        8'hA7, 8'h74, 8'hD3, 8'hA1, 8'hAA, 8'h8B, 8'h99, 8'hAE,
        8'h9E, 8'h78, 8'h30, 8'hA7, 8'h74, 8'hD3, 8'h82, 8'h82,
        8'h82, 8'h15, 8'h9C, 8'h9C, 8'h9E, 8'h38, 8'h40, 8'h3E,
        8'h82, 8'h82, 8'h82, 8'h15, 8'h9C, 8'h9C, 8'h9E, 8'h38,
        8'h40, 8'h3E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    localparam logic [7:0] TAIL_IMAGE [64] = '{
        8'h00, 8'h00, 8'h00, 8'hFF, 8'h11, 8'hEE, 8'h00, 8'h00,
        8'h33, 8'hCC, 8'h44, 8'hBB, 8'h00, 8'h00, 8'h66, 8'h99,
        8'h77, 8'h88, 8'h00, 8'h00, 8'h2B, 8'h01, 8'hE8, 8'h13,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // Reset content of one EEPROM byte.
    function automatic logic [7:0] cmm_init_byte(input logic [15:0] addr);
        logic [7:0]  value;
        logic [15:0] tail_ofs;
        value    = 8'h00;
        tail_ofs = addr - TAIL_BASE;
        if (addr < CAL_END) begin
            value = CAL_IMAGE[addr[5:0]];
        end else if (addr >= TAIL_BASE && addr < TAIL_END) begin
            value = TAIL_IMAGE[tail_ofs[5:0]];
        end
        return value;
    endfunction

endpackage

// ===== hw/rtl/cmm_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle, write or read, with registered read data.
// ----------------------------------------------------------------------------
module cmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic             i_re,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/controller_memory_map_unit.sv =====
// ----------------------------------------------------------------------------
// Controller memory map unit
// A result appears in the cycle after its transaction is accepted.
// Throughput: one byte access per cycle while the result output is not stalled,
// set by the single RAM port of each store. Reset: a load pass over
// max(EEPROM_BYTES, 4 * 2**clog2(BLOCK_BYTES)) addresses writes the reset image into
// the EEPROM and zeros the register blocks; no transaction is accepted until it ends.
// ----------------------------------------------------------------------------
module controller_memory_map_unit #(
    parameter int EEPROM_BYTES = 5888,
    parameter int BLOCK_BYTES  = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // start_address[23:0], transfer_length[39:24], byte_index[55:40], write_byte[63:56]
    input  logic [63:0] i_s_axis_tdata,
    // kind[0], in_register_space[1]
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // read_byte[7:0], status[9:8], zero[15:10]
    output logic [15:0] o_m_axis_tdata
);
    import cmm_pkg::*;

    localparam int EAW       = $clog2(EEPROM_BYTES);
    localparam int BW        = $clog2(BLOCK_BYTES);
    localparam int RAW       = BW + 2;
    localparam int REG_DEPTH = 1 << RAW;
    localparam int CLR_DEPTH = (EEPROM_BYTES > REG_DEPTH) ? EEPROM_BYTES : REG_DEPTH;
    localparam int CW        = $clog2(CLR_DEPTH + 1);

    typedef enum logic [1:0] {
        BLK_SPEAKER   = 2'd0,
        BLK_EXTENSION = 2'd1,
        BLK_MOTION    = 2'd2,
        BLK_IR        = 2'd3
    } t_block;

    logic            r_clearing;
    logic [CW-1:0]   r_clr_cnt;
    logic            r_s1_valid;
    t_status         r_s1_status;
    logic            r_s1_rd_eep;
    logic            r_s1_rd_reg;

    logic            n_clearing;
    logic [CW-1:0]   n_clr_cnt;
    logic            n_s1_valid;

    logic            kind;
    logic            reg_space;
    logic [23:0]     start_address;
    logic [15:0]     transfer_length;
    logic [15:0]     byte_index;
    logic [7:0]      write_byte;

    logic            accept;
    logic            advance;
    logic            idx_ok;
    logic [16:0]     eep_sum;
    logic [15:0]     eep_where;
    logic            eep_fit;
    logic [16:0]     reg_sum;
    logic [15:0]     reg_where;
    logic            reg_fit;
    logic            blk_known;
    t_block          blk;
    t_status         status;
    logic            eep_hit;
    logic            reg_hit;

    logic            eep_we;
    logic            eep_re;
    logic [EAW-1:0]  eep_addr;
    logic [7:0]      eep_wdata;
    logic [7:0]      eep_q;
    logic            reg_we;
    logic            reg_re;
    logic [RAW-1:0]  reg_addr;
    logic [7:0]      reg_wdata;
    logic [7:0]      reg_q;
    logic [7:0]      read_byte;

    assign start_address   = i_s_axis_tdata[23:0];
    assign transfer_length = i_s_axis_tdata[39:24];
    assign byte_index      = i_s_axis_tdata[55:40];
    assign write_byte      = i_s_axis_tdata[63:56];
    assign kind            = i_s_axis_tuser[0];
    assign reg_space       = i_s_axis_tuser[1];

    assign advance         = !r_s1_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_clearing && advance;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        idx_ok    = byte_index < transfer_length;
        eep_sum   = {1'b0, start_address[15:0]} + {1'b0, transfer_length};
        eep_fit   = eep_sum <= 17'(EEPROM_BYTES);
        eep_where = start_address[15:0] + byte_index;
        reg_sum   = {9'd0, start_address[7:0]} + {1'b0, transfer_length};
        reg_fit   = reg_sum <= 17'(BLOCK_BYTES);
        reg_where = {8'd0, start_address[7:0]} + byte_index;

        blk_known = 1'b1;
        case (start_address[23:16])
            BASE_SPEAKER:   blk = BLK_SPEAKER;
            BASE_EXTENSION: blk = BLK_EXTENSION;
            BASE_MOTION:    blk = BLK_MOTION;
            BASE_IR:        blk = BLK_IR;
            default: begin
                blk       = BLK_SPEAKER;
                blk_known = 1'b0;
            end
        endcase

        eep_hit = 1'b0;
        reg_hit = 1'b0;
        if (transfer_length == 16'd0) begin
            status = ST_EMPTY;
        end else if (!reg_space) begin
            eep_hit = eep_fit && idx_ok;
            status  = eep_hit ? ST_OK : ST_BAD_ADDR;
        end else if (!blk_known) begin
            status = ST_BAD_ADDR;
        end else begin
            reg_hit = reg_fit && idx_ok;
            status  = reg_hit ? ST_OK : ST_NACK;
        end
    end

    always_comb begin
        if (r_clearing) begin
            eep_we    = r_clr_cnt < CW'(EEPROM_BYTES);
            eep_re    = 1'b0;
            eep_addr  = r_clr_cnt[EAW-1:0];
            eep_wdata = cmm_init_byte(16'(r_clr_cnt));
            reg_we    = r_clr_cnt < CW'(REG_DEPTH);
            reg_re    = 1'b0;
            reg_addr  = r_clr_cnt[RAW-1:0];
            reg_wdata = 8'h00;
        end else begin
            eep_we    = accept && eep_hit && kind;
            eep_re    = accept && eep_hit && !kind;
            eep_addr  = eep_where[EAW-1:0];
            eep_wdata = write_byte;
            reg_we    = accept && reg_hit && kind;
            reg_re    = accept && reg_hit && !kind;
            reg_addr  = {blk, reg_where[BW-1:0]};
            reg_wdata = write_byte;
        end
    end

    always_comb begin
        n_clearing = r_clearing;
        n_clr_cnt  = r_clr_cnt;
        if (r_clearing) begin
            n_clr_cnt = r_clr_cnt + CW'(1);
            if (r_clr_cnt == CW'(CLR_DEPTH - 1)) begin
                n_clearing = 1'b0;
            end
        end
        n_s1_valid = accept ? 1'b1 : (i_m_axis_tready ? 1'b0 : r_s1_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_cnt  <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_clearing <= n_clearing;
            r_clr_cnt  <= n_clr_cnt;
            r_s1_valid <= n_s1_valid;
        end
        if (accept) begin
            r_s1_status <= status;
            r_s1_rd_eep <= eep_hit && !kind;
            r_s1_rd_reg <= reg_hit && !kind;
        end
    end

    cmm_ram #(
        .WIDTH (8),
        .DEPTH (EEPROM_BYTES)
    ) u_eeprom_ram (
        .i_clk   (i_clk),
        .i_we    (eep_we),
        .i_re    (eep_re),
        .i_addr  (eep_addr),
        .i_wdata (eep_wdata),
        .o_rdata (eep_q)
    );

    cmm_ram #(
        .WIDTH (8),
        .DEPTH (REG_DEPTH)
    ) u_reg_ram (
        .i_clk   (i_clk),
        .i_we    (reg_we),
        .i_re    (reg_re),
        .i_addr  (reg_addr),
        .i_wdata (reg_wdata),
        .o_rdata (reg_q)
    );

    assign read_byte       = r_s1_rd_eep ? eep_q : (r_s1_rd_reg ? reg_q : 8'h00);
    assign o_m_axis_tvalid = r_s1_valid;
    assign o_m_axis_tdata  = {6'd0, r_s1_status, read_byte};

endmodule

// ===== hw/rtl/cmm_checker.sv =====
// ----------------------------------------------------------------------------
// Controller memory map checker
// Port-level checks of result status, read data and output timing.
// ----------------------------------------------------------------------------
`include "controller_memory_map_unit_macros.svh"

module cmm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [63:0] i_s_axis_tdata,
    input logic [1:0]  i_s_axis_tuser,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata
);
    import cmm_pkg::*;

    logic in_txn;
    logic failed_out;
    logic empty_in;
    logic empty_out;
    logic eeprom_in;
    logic out_stall;

    assign in_txn     = i_s_axis_tvalid && o_s_axis_tready;
    assign failed_out = o_m_axis_tvalid && (o_m_axis_tdata[9:8] != ST_OK);
    assign empty_in   = in_txn && (i_s_axis_tdata[39:24] == 16'd0);
    assign empty_out  = o_m_axis_tvalid && (o_m_axis_tdata[9:8] == ST_EMPTY);
    assign eeprom_in  = in_txn && !i_s_axis_tuser[1];
    assign out_stall  = o_m_axis_tvalid && !i_m_axis_tready;

    // A failed access never returns data.
    `CMM_ASSERT_SAME(a_fail_reads_zero, i_clk, i_rst_n, failed_out, o_m_axis_tdata[7:0] == 8'h00)

    // An empty transfer is answered in the next cycle with the empty status.
    `CMM_ASSERT_NEXT(a_empty_next, i_clk, i_rst_n, empty_in, empty_out)

    // EEPROM space never answers with NACK.
    `CMM_ASSERT_NEXT(a_eeprom_no_nack, i_clk, i_rst_n, eeprom_in, o_m_axis_tdata[9:8] != ST_NACK)

    // A stalled result holds its content.
    `CMM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_m_axis_tvalid && $stable(o_m_axis_tdata))

endmodule

bind controller_memory_map_unit cmm_checker u_cmm_checker (.*);
